[rtl/quad_element_jacobian_metrics_top_defines.svh]
// Assertion macros for the quad element Jacobian metrics block.
// Used by quad_element_jacobian_metrics_top.sv; needs clk and rst_n in scope.
`ifndef QUAD_ELEMENT_JACOBIAN_METRICS_TOP_DEFINES_SVH
`define QUAD_ELEMENT_JACOBIAN_METRICS_TOP_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define QEJM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define QEJM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qejm_pkg.sv]
// Shared types for the quad element Jacobian metrics block.
// No dependencies.
package qejm_pkg;

    // Point kinds carried by the command field.
    typedef enum logic [2:0] {
        CMD_VOLUME    = 3'd0,
        CMD_FACE_IMIN = 3'd1,
        CMD_FACE_IMAX = 3'd2,
        CMD_FACE_JMIN = 3'd3,
        CMD_FACE_JMAX = 3'd4
    } cmd_t;

endpackage

[rtl/qejm_div_pipe.sv]
// Pipelined restoring divider: ((mag << FRAC_BITS) + den/2) / den, one bit a stage.
// Standalone; used by quad_element_jacobian_metrics_top.
module qejm_div_pipe #(
    parameter int QUOT_BITS = 33,
    parameter int FRAC_BITS = 16,
    parameter int MAG_WIDTH = 32,
    parameter int DEN_WIDTH = 33
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [MAG_WIDTH-1:0] mag,
    input  logic [DEN_WIDTH-1:0] den,
    input  logic                 neg,
    output logic [QUOT_BITS-1:0] quot,
    output logic                 quot_neg
);

    localparam int NUM_WIDTH = MAG_WIDTH + FRAC_BITS + 1;
    localparam int REM_WIDTH = (NUM_WIDTH > DEN_WIDTH + QUOT_BITS) ?
                               NUM_WIDTH : DEN_WIDTH + QUOT_BITS;

    logic [REM_WIDTH-1:0] rem_reg  [0:QUOT_BITS];
    logic [REM_WIDTH-1:0] rem_next [0:QUOT_BITS];
    logic [DEN_WIDTH-1:0] den_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_next[0:QUOT_BITS];
    logic                 neg_reg  [0:QUOT_BITS];
    logic [REM_WIDTH-1:0] trial    [0:QUOT_BITS];

    // Entry stage forms the rounded dividend; each later stage settles one quotient bit.
    always_comb
    begin
        rem_next[0]  = (REM_WIDTH'(mag) << FRAC_BITS) + REM_WIDTH'(den >> 1);
        quot_next[0] = '0;
        trial[0]     = '0;
        for (int k = 1; k <= QUOT_BITS; k++)
        begin
            trial[k] = REM_WIDTH'(den_reg[k-1]) << (QUOT_BITS - k);
            if (rem_reg[k-1] >= trial[k])
            begin
                rem_next[k]  = rem_reg[k-1] - trial[k];
                quot_next[k] = quot_reg[k-1] | (QUOT_BITS'(1) << (QUOT_BITS - k));
            end
            else
            begin
                rem_next[k]  = rem_reg[k-1];
                quot_next[k] = quot_reg[k-1];
            end
        end
    end

    // Stage registers advance together with the host pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            den_reg[0]  <= den;
            quot_reg[0] <= quot_next[0];
            neg_reg[0]  <= neg;
            for (int k = 1; k <= QUOT_BITS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_reg[k-1];
                quot_reg[k] <= quot_next[k];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    assign quot     = quot_reg[QUOT_BITS];
    assign quot_neg = neg_reg[QUOT_BITS];

endmodule

[rtl/quad_element_jacobian_metrics_top.sv]
// Jacobian determinant, inverse metric terms and face normal of one element point.
// Depends on qejm_pkg, qejm_div_pipe and quad_element_jacobian_metrics_top_defines.svh.
//
//   channel | handshake               | word
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid / in_stall     | command, dx_dr, dx_ds, dy_dr, dy_ds
//   out     | out_valid / out_stall   | jacobian, metrics, normal, status
//
// One word enters per cycle while in_stall is low. The pipeline length is set by
// the DATA_WIDTH-stage square root followed by the DATA_WIDTH+2-stage dividers; each
// root stage and each divider stage after the entry stage settles one result bit.
// Reset clears only the valid bits. A stalled output word freezes the whole
// pipeline, and in_stall rises in the same cycle.
`include "quad_element_jacobian_metrics_top_defines.svh"

module quad_element_jacobian_metrics_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   command,
    input  logic signed [DATA_WIDTH-1:0] dx_dr,
    input  logic signed [DATA_WIDTH-1:0] dx_ds,
    input  logic signed [DATA_WIDTH-1:0] dy_dr,
    input  logic signed [DATA_WIDTH-1:0] dy_ds,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] jacobian,
    output logic signed [DATA_WIDTH-1:0] dr_dx,
    output logic signed [DATA_WIDTH-1:0] dr_dy,
    output logic signed [DATA_WIDTH-1:0] ds_dx,
    output logic signed [DATA_WIDTH-1:0] ds_dy,
    output logic [DATA_WIDTH-2:0]        normal_length,
    output logic signed [FRAC_BITS+1:0]  unit_normal_x,
    output logic signed [FRAC_BITS+1:0]  unit_normal_y,
    output logic                         status
);

    import qejm_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int D   = W + 2;
    localparam int NST = 2 * W + 7;

    localparam logic signed [2*W:0] HALF_LSB   = (2 * W + 1)'(1) << (F - 1);
    localparam logic [W:0]          LEN_MAX    = {2'b00, {(W - 1){1'b1}}};
    localparam logic [W:0]          HALF_RANGE = (W + 1)'(1) << (W - 1);
    localparam logic [W:0]          ONE_Q      = (W + 1)'(1) << F;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Valid bits and the global advance.
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv      = !vld_reg[NST-1] || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Stage 1: input word.
    logic [2:0]          cmd_reg;
    logic signed [W-1:0] xr_reg, xs_reg, yr_reg, ys_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_reg <= command;
            xr_reg  <= dx_dr;
            xs_reg  <= dx_ds;
            yr_reg  <= dy_dr;
            ys_reg  <= dy_ds;
        end
    end

    // Stage 2: products, magnitudes and normal signs.
    logic signed [2*W-1:0] pa_next, pb_next, pa_reg, pb_reg;
    logic [W-1:0]          mag_next [0:3];
    logic [W-1:0]          mag2_reg [0:3];
    logic [W-1:0]          ax_next, ay_next;
    logic [2*W-1:0]        ax2_reg, ay2_reg;
    logic [3:0]            neg_next, neg2_reg;
    logic [1:0]            uneg_next, uneg2_reg;
    logic                  face_next, jface_next, face2_reg, jface2_reg;

    always_comb
    begin
        pa_next     = xr_reg * ys_reg;
        pb_next     = yr_reg * xs_reg;
        mag_next[0] = mag_of(ys_reg);
        mag_next[1] = mag_of(xs_reg);
        mag_next[2] = mag_of(yr_reg);
        mag_next[3] = mag_of(xr_reg);
        neg_next    = {xr_reg[W-1], !yr_reg[W-1], !xs_reg[W-1], ys_reg[W-1]};
        face_next   = 1'b1;
        jface_next  = 1'b0;
        uneg_next   = 2'b00;
        case (cmd_reg)
            CMD_FACE_IMIN: uneg_next = {xs_reg[W-1], !ys_reg[W-1]};
            CMD_FACE_IMAX: uneg_next = {!xs_reg[W-1], ys_reg[W-1]};
            CMD_FACE_JMIN:
            begin
                jface_next = 1'b1;
                uneg_next  = {!xr_reg[W-1], yr_reg[W-1]};
            end
            CMD_FACE_JMAX:
            begin
                jface_next = 1'b1;
                uneg_next  = {xr_reg[W-1], !yr_reg[W-1]};
            end
            default: face_next = 1'b0;
        endcase
        ax_next = jface_next ? mag_next[2] : mag_next[0];
        ay_next = jface_next ? mag_next[3] : mag_next[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            ax2_reg    <= ax_next * ax_next;
            ay2_reg    <= ay_next * ay_next;
            mag2_reg   <= mag_next;
            neg2_reg   <= neg_next;
            uneg2_reg  <= uneg_next;
            face2_reg  <= face_next;
            jface2_reg <= jface_next;
        end
    end

    // Stage 3: rounded, saturated Jacobian and the squared normal length.
    logic signed [2*W:0]   s3_sum, s3_shift;
    logic signed [W-1:0]   jac_next;
    logic                  stat_next;

    always_comb
    begin
        s3_sum   = (2 * W + 1)'(pa_reg) - (2 * W + 1)'(pb_reg) + HALF_LSB;
        s3_shift = s3_sum >>> F;
        if (s3_shift[2*W:W-1] == '0 || s3_shift[2*W:W-1] == '1)
        begin
            jac_next = s3_shift[W-1:0];
        end
        else if (s3_shift[2*W])
        begin
            jac_next = {1'b1, {(W - 1){1'b0}}};
        end
        else
        begin
            jac_next = {1'b0, {(W - 1){1'b1}}};
        end
        stat_next = jac_next[W-1] || (jac_next == '0);
    end

    // Square root stages: element 0 holds stage 3, each later one settles a root bit.
    logic [2*W-1:0]      sq_rem_reg   [0:W];
    logic [2*W-1:0]      sq_rem_next  [0:W];
    logic [W-1:0]        sq_root_reg  [0:W];
    logic [W-1:0]        sq_root_next [0:W];
    logic [2*W:0]        sq_trial     [0:W];
    logic signed [W-1:0] sq_jac_reg   [0:W];
    logic                sq_stat_reg  [0:W];
    logic                sq_face_reg  [0:W];
    logic                sq_jface_reg [0:W];
    logic [W-1:0]        sq_mag_reg   [0:W][0:3];
    logic [3:0]          sq_neg_reg   [0:W];
    logic [1:0]          sq_uneg_reg  [0:W];

    always_comb
    begin
        sq_rem_next[0]  = ax2_reg + ay2_reg;
        sq_root_next[0] = '0;
        sq_trial[0]     = '0;
        for (int k = 1; k <= W; k++)
        begin
            sq_trial[k] = ((2 * W + 1)'(sq_root_reg[k-1]) << (W - k + 1))
                        + ((2 * W + 1)'(1) << (2 * (W - k)));
            if ({1'b0, sq_rem_reg[k-1]} >= sq_trial[k])
            begin
                sq_rem_next[k]  = sq_rem_reg[k-1] - sq_trial[k][2*W-1:0];
                sq_root_next[k] = sq_root_reg[k-1] | (W'(1) << (W - k));
            end
            else
            begin
                sq_rem_next[k]  = sq_rem_reg[k-1];
                sq_root_next[k] = sq_root_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]   <= sq_rem_next[0];
            sq_root_reg[0]  <= sq_root_next[0];
            sq_jac_reg[0]   <= jac_next;
            sq_stat_reg[0]  <= stat_next;
            sq_face_reg[0]  <= face2_reg;
            sq_jface_reg[0] <= jface2_reg;
            sq_mag_reg[0]   <= mag2_reg;
            sq_neg_reg[0]   <= neg2_reg;
            sq_uneg_reg[0]  <= uneg2_reg;
            for (int k = 1; k <= W; k++)
            begin
                sq_rem_reg[k]   <= sq_rem_next[k];
                sq_root_reg[k]  <= sq_root_next[k];
                sq_jac_reg[k]   <= sq_jac_reg[k-1];
                sq_stat_reg[k]  <= sq_stat_reg[k-1];
                sq_face_reg[k]  <= sq_face_reg[k-1];
                sq_jface_reg[k] <= sq_jface_reg[k-1];
                sq_mag_reg[k]   <= sq_mag_reg[k-1];
                sq_neg_reg[k]   <= sq_neg_reg[k-1];
                sq_uneg_reg[k]  <= sq_uneg_reg[k-1];
            end
        end
    end

    // Rounding stage: nearest integer root, saturated copy for the length field.
    logic                rnd_up;
    logic [W:0]          len_next;
    logic [W:0]          rd_len_reg;
    logic signed [W-1:0] rd_jac_reg;
    logic [W-1:0]        rd_mag_reg [0:3];
    logic [3:0]          rd_neg_reg;
    logic [1:0]          rd_uneg_reg;
    logic                rd_jface_reg;

    // Side data that waits while the dividers run; element 0 is the rounding stage.
    logic signed [W-1:0] tl_jac_reg     [0:D];
    logic                tl_stat_reg    [0:D];
    logic                tl_face_reg    [0:D];
    logic [W-2:0]        tl_lenout_reg  [0:D];
    logic                tl_lenzero_reg [0:D];

    always_comb
    begin
        rnd_up   = sq_rem_reg[W] > (2 * W)'(sq_root_reg[W]);
        len_next = {1'b0, sq_root_reg[W]} + (W + 1)'(rnd_up);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_len_reg        <= len_next;
            rd_jac_reg        <= sq_jac_reg[W];
            rd_mag_reg        <= sq_mag_reg[W];
            rd_neg_reg        <= sq_neg_reg[W];
            rd_uneg_reg       <= sq_uneg_reg[W];
            rd_jface_reg      <= sq_jface_reg[W];
            tl_jac_reg[0]     <= sq_jac_reg[W];
            tl_stat_reg[0]    <= sq_stat_reg[W];
            tl_face_reg[0]    <= sq_face_reg[W];
            tl_lenout_reg[0]  <= (len_next > LEN_MAX) ? LEN_MAX[W-2:0] : len_next[W-2:0];
            tl_lenzero_reg[0] <= (len_next == '0);
            for (int k = 1; k <= D; k++)
            begin
                tl_jac_reg[k]     <= tl_jac_reg[k-1];
                tl_stat_reg[k]    <= tl_stat_reg[k-1];
                tl_face_reg[k]    <= tl_face_reg[k-1];
                tl_lenout_reg[k]  <= tl_lenout_reg[k-1];
                tl_lenzero_reg[k] <= tl_lenzero_reg[k-1];
            end
        end
    end

    // Dividers: four metric terms over the Jacobian, two unit components over the length.
    logic [W:0] mq   [0:3];
    logic       mneg [0:3];
    logic [W:0] uq   [0:1];
    logic       uneg [0:1];

    for (genvar g = 0; g < 4; g++)
    begin : g_metric_div
        qejm_div_pipe #(
            .QUOT_BITS (W + 1),
            .FRAC_BITS (F),
            .MAG_WIDTH (W),
            .DEN_WIDTH (W + 1)
        ) u_div (
            .clk      (clk),
            .en       (adv),
            .mag      (rd_mag_reg[g]),
            .den      ({1'b0, rd_jac_reg}),
            .neg      (rd_neg_reg[g]),
            .quot     (mq[g]),
            .quot_neg (mneg[g])
        );
    end

    for (genvar g = 0; g < 2; g++)
    begin : g_unit_div
        qejm_div_pipe #(
            .QUOT_BITS (W + 1),
            .FRAC_BITS (F),
            .MAG_WIDTH (W),
            .DEN_WIDTH (W + 1)
        ) u_div (
            .clk      (clk),
            .en       (adv),
            .mag      (rd_jface_reg ? rd_mag_reg[g + 2] : rd_mag_reg[g]),
            .den      (rd_len_reg),
            .neg      (rd_uneg_reg[g]),
            .quot     (uq[g]),
            .quot_neg (uneg[g])
        );
    end

    // Output stage: saturate the metric terms, clamp the unit normal, clear unused fields.
    logic signed [W-1:0] met_next [0:3];
    logic [W:0]          uclamp   [0:1];
    logic signed [F+1:0] unit_next[0:1];

    logic signed [W-1:0] jacobian_reg, dr_dx_reg, dr_dy_reg, ds_dx_reg, ds_dy_reg;
    logic [W-2:0]        normal_length_reg;
    logic signed [F+1:0] unit_normal_x_reg, unit_normal_y_reg;
    logic                status_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (tl_stat_reg[D])
            begin
                met_next[k] = '0;
            end
            else if (!mneg[k])
            begin
                met_next[k] = (mq[k] >= HALF_RANGE) ? {1'b0, {(W - 1){1'b1}}} : mq[k][W-1:0];
            end
            else
            begin
                met_next[k] = (mq[k] > HALF_RANGE) ? {1'b1, {(W - 1){1'b0}}}
                                                   : (~mq[k][W-1:0] + 1'b1);
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            uclamp[k] = (uq[k] > ONE_Q) ? ONE_Q : uq[k];
            if (!tl_face_reg[D] || tl_lenzero_reg[D])
            begin
                unit_next[k] = '0;
            end
            else if (uneg[k])
            begin
                unit_next[k] = ~(F + 2)'(uclamp[k]) + 1'b1;
            end
            else
            begin
                unit_next[k] = (F + 2)'(uclamp[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            jacobian_reg      <= tl_jac_reg[D];
            dr_dx_reg         <= met_next[0];
            dr_dy_reg         <= met_next[1];
            ds_dx_reg         <= met_next[2];
            ds_dy_reg         <= met_next[3];
            normal_length_reg <= tl_face_reg[D] ? tl_lenout_reg[D] : '0;
            unit_normal_x_reg <= unit_next[0];
            unit_normal_y_reg <= unit_next[1];
            status_reg        <= tl_stat_reg[D];
        end
    end

    assign out_valid     = vld_reg[NST-1];
    assign jacobian      = jacobian_reg;
    assign dr_dx         = dr_dx_reg;
    assign dr_dy         = dr_dy_reg;
    assign ds_dx         = ds_dx_reg;
    assign ds_dy         = ds_dy_reg;
    assign normal_length = normal_length_reg;
    assign unit_normal_x = unit_normal_x_reg;
    assign unit_normal_y = unit_normal_y_reg;
    assign status        = status_reg;

    // Checks on the output word and on the pipeline drain.
    `QEJM_ASSERT_SAME(a_bad_jac_clears_metrics, out_valid && status, dr_dx == '0 && dr_dy == '0 && ds_dx == '0 && ds_dy == '0, "metric terms not cleared for a bad Jacobian")
    `QEJM_ASSERT_SAME(a_status_follows_jac, out_valid, status == (jacobian[DATA_WIDTH-1] || jacobian == '0), "status disagrees with the Jacobian sign")
    `QEJM_ASSERT_SAME(a_zero_len_zero_unit, out_valid && normal_length == '0, unit_normal_x == '0 && unit_normal_y == '0, "unit normal set with zero length")
    `QEJM_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !vld_reg[NST-2], !out_valid, "output word repeated after a drain")

endmodule
